// ===== rtl/core/lla_pkg.sv =====
`timescale 1ns / 1ps

package lla_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;

    localparam int OP_W    = 2;
    localparam int COORD_W = 6;
    localparam int MASK_W  = 9;
    localparam int CFG_IDX_W = 1;

    localparam int COL_AW = $clog2(GRID_WIDTH);
    localparam int ROW_AW = $clog2(GRID_HEIGHT);
    // sweep runs two steps past the last row to drain the row window
    localparam int STEP_W = $clog2(GRID_HEIGHT + 2);

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BIRTH    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURVIVAL = 1'd1;

    localparam logic [MASK_W-1:0] BIRTH_RESET    = 9'd8;
    localparam logic [MASK_W-1:0] SURVIVAL_RESET = 9'd12;

    typedef struct packed {
        logic              capture;
        logic              rd_item;
        logic              rd_adv;
        logic [STEP_W-1:0] step;
        logic              cell_upd;
        logic              adv_step;
        logic              swap;
        logic              out_load;
    } lla_cmd_t;

    typedef struct packed {
        logic out_busy;
    } lla_status_t;

endpackage

// ===== rtl/core/lla_ram.sv =====
`timescale 1ns / 1ps

module lla_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/lla_rule_row.sv =====
`timescale 1ns / 1ps

module lla_rule_row (
    input  logic [lla_pkg::GRID_WIDTH-1:0] above,
    input  logic [lla_pkg::GRID_WIDTH-1:0] middle,
    input  logic [lla_pkg::GRID_WIDTH-1:0] below,
    input  logic [lla_pkg::MASK_W-1:0]     birth,
    input  logic [lla_pkg::MASK_W-1:0]     survival,
    output logic [lla_pkg::GRID_WIDTH-1:0] next_row
);
    import lla_pkg::*;

    // zero padding on both sides: cells off the grid are dead
    logic [GRID_WIDTH+1:0] a_p;
    logic [GRID_WIDTH+1:0] m_p;
    logic [GRID_WIDTH+1:0] b_p;

    assign a_p = {1'b0, above, 1'b0};
    assign m_p = {1'b0, middle, 1'b0};
    assign b_p = {1'b0, below, 1'b0};

    for (genvar c = 0; c < GRID_WIDTH; c++)
    begin : g_cell
        logic [3:0] cnt;

        assign cnt = 4'(a_p[c]) + 4'(a_p[c+1]) + 4'(a_p[c+2])
                   + 4'(m_p[c]) + 4'(m_p[c+2])
                   + 4'(b_p[c]) + 4'(b_p[c+1]) + 4'(b_p[c+2]);
        assign next_row[c] = m_p[c+1] ? survival[cnt] : birth[cnt];
    end

endmodule

// ===== rtl/core/lla_datapath.sv =====
`timescale 1ns / 1ps

module lla_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lla_pkg::lla_cmd_t               cmd,
    output lla_pkg::lla_status_t            status,
    input  logic [lla_pkg::OP_W-1:0]        operation,
    input  logic [lla_pkg::COORD_W-1:0]     column,
    input  logic [lla_pkg::COORD_W-1:0]     row,
    input  logic                            alive_in,
    input  logic                            cfg_wr_en,
    input  logic [lla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lla_pkg::MASK_W-1:0]      cfg_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            alive_out,
    output logic [lla_pkg::OP_W-1:0]        operation_done
);
    import lla_pkg::*;

    logic [MASK_W-1:0] birth_reg;
    logic [MASK_W-1:0] surv_reg;
    logic              active_reg;
    logic [GRID_HEIGHT-1:0] vld0_reg;
    logic [GRID_HEIGHT-1:0] vld1_reg;
    logic              rd_valid_reg;
    logic              out_valid_reg;

    logic [OP_W-1:0]    op_reg;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    logic               alive_reg;
    logic               in_grid_reg;
    logic               res_alive_reg;
    logic               alive_out_reg;
    logic [OP_W-1:0]    op_done_reg;
    logic [GRID_WIDTH-1:0] win_a_reg;
    logic [GRID_WIDTH-1:0] win_b_reg;

    logic [COL_AW-1:0]     col_idx;
    logic [ROW_AW-1:0]     row_idx;
    logic                  rd_en;
    logic [ROW_AW-1:0]     rd_addr;
    logic                  rd_valid_next;
    logic [GRID_WIDTH-1:0] q0;
    logic [GRID_WIDTH-1:0] q1;
    logic [GRID_WIDTH-1:0] q_row;
    logic [GRID_WIDTH-1:0] upd_row;
    logic [GRID_WIDTH-1:0] rule_row;
    logic [STEP_W-1:0]     step_back;
    logic                  wr_en;
    logic                  wr_plane;
    logic [ROW_AW-1:0]     wr_addr;
    logic [GRID_WIDTH-1:0] wr_data;
    logic                  in_grid;

    assign in_grid = (32'(column) < 32'(GRID_WIDTH)) && (32'(row) < 32'(GRID_HEIGHT));
    assign col_idx = COL_AW'(col_reg);
    assign row_idx = ROW_AW'(row_reg);

    assign rd_en   = cmd.rd_item | cmd.rd_adv;
    assign rd_addr = cmd.rd_adv ? ROW_AW'(cmd.step) : row_idx;
    assign rd_valid_next = rd_en & (active_reg ? vld1_reg[rd_addr] : vld0_reg[rd_addr]);

    // rows never written since reset read as all dead
    assign q_row = rd_valid_reg ? (active_reg ? q1 : q0) : '0;

    always_comb
    begin
        upd_row = q_row;
        upd_row[col_idx] = alive_reg;
    end

    lla_rule_row u_rule (
        .above    (win_a_reg),
        .middle   (win_b_reg),
        .below    (q_row),
        .birth    (birth_reg),
        .survival (surv_reg),
        .next_row (rule_row)
    );

    assign step_back = cmd.step - STEP_W'(2);

    always_comb
    begin
        if (cmd.cell_upd)
        begin
            wr_en    = (op_reg == OP_WRITE) && in_grid_reg;
            wr_plane = active_reg;
            wr_addr  = row_idx;
            wr_data  = upd_row;
        end
        else
        begin
            wr_en    = cmd.adv_step && (cmd.step >= STEP_W'(2));
            wr_plane = ~active_reg;
            wr_addr  = ROW_AW'(step_back);
            wr_data  = rule_row;
        end
    end

    lla_ram #(
        .WIDTH (GRID_WIDTH),
        .DEPTH (GRID_HEIGHT)
    ) u_plane0 (
        .clk     (clk),
        .wr_en   (wr_en & ~wr_plane),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (q0)
    );

    lla_ram #(
        .WIDTH (GRID_WIDTH),
        .DEPTH (GRID_HEIGHT)
    ) u_plane1 (
        .clk     (clk),
        .wr_en   (wr_en & wr_plane),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (q1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            birth_reg     <= BIRTH_RESET;
            surv_reg      <= SURVIVAL_RESET;
            active_reg    <= 1'b0;
            vld0_reg      <= '0;
            vld1_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en && cfg_index == REG_BIRTH)
            begin
                birth_reg <= cfg_data;
            end
            if (cfg_wr_en && cfg_index == REG_SURVIVAL)
            begin
                surv_reg <= cfg_data;
            end
            if (cmd.swap)
            begin
                active_reg <= ~active_reg;
            end
            if (wr_en && !wr_plane)
            begin
                vld0_reg[wr_addr] <= 1'b1;
            end
            if (wr_en && wr_plane)
            begin
                vld1_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= rd_valid_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= operation;
            col_reg       <= column;
            row_reg       <= row;
            alive_reg     <= alive_in;
            in_grid_reg   <= in_grid;
            res_alive_reg <= 1'b0;
            win_a_reg     <= '0;
            win_b_reg     <= '0;
        end
        if (cmd.cell_upd)
        begin
            res_alive_reg <= (op_reg == OP_READ) && in_grid_reg && q_row[col_idx];
        end
        if (cmd.adv_step)
        begin
            win_a_reg <= win_b_reg;
            win_b_reg <= q_row;
        end
        if (cmd.out_load)
        begin
            alive_out_reg <= res_alive_reg;
            op_done_reg   <= op_reg;
        end
    end

    assign status.out_busy = out_valid_reg & ~out_ready;
    assign out_valid       = out_valid_reg;
    assign alive_out       = alive_out_reg;
    assign operation_done  = op_done_reg;

endmodule

// ===== rtl/core/lla_ctrl.sv =====
`timescale 1ns / 1ps

module lla_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [lla_pkg::OP_W-1:0] operation,
    input  lla_pkg::lla_status_t     status,
    output lla_pkg::lla_cmd_t        cmd
);
    import lla_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_RDW  = 3'd2;
    localparam logic [2:0] ST_ADV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    step_next   = '0;
                    case (operation)
                        OP_WRITE, OP_READ: state_next = ST_RD;
                        OP_ADVANCE:        state_next = ST_ADV;
                        default:           state_next = ST_FIN;
                    endcase
                end
            end
            ST_RD:
            begin
                cmd.rd_item = 1'b1;
                state_next  = ST_RDW;
            end
            ST_RDW:
            begin
                cmd.cell_upd = 1'b1;
                state_next   = ST_FIN;
            end
            ST_ADV:
            begin
                // step s reads row s and writes row s-2
                cmd.rd_adv   = (step_reg < STEP_W'(GRID_HEIGHT));
                cmd.adv_step = 1'b1;
                if (step_reg == STEP_W'(GRID_HEIGHT + 1))
                begin
                    cmd.swap   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== rtl/core/life_like_automaton_step.sv =====
`timescale 1ns / 1ps
// Life-like cellular automaton (B/S rule) on a bounded 64 x 64 grid, no wrap.
// Input channel (in_valid/in_ready): operation, column, row, alive_in.
//   write cell, advance one generation, or read cell. One item at a time;
//   in_ready is high only while the block is idle.
// Output channel (out_valid/out_ready): alive_out, operation_done, one result
//   per item, held in an output register until the transfer.
// Config port: cfg_wr_en, cfg_index (0 birth mask, 1 survival mask), cfg_data.
// Steps from input transfer to result valid:
//   write or read cell: row read from the plane RAM, then written back for a write
//   advance: the sweep takes one grid row per cycle through a three-row window,
//   bounded by one RAM read port per plane
//   unused operation code: no RAM access, the result is loaded directly
// A new item is taken the cycle after its predecessor's result is loaded into
// the output register. If the receiver stalls with a result still pending, the
// next item finishes its work and waits until the output register is free.
// Reset: both planes read as all dead (per-row valid bits, no clearing pass),
// active plane 0, birth mask 8, survival mask 12, output channel empty.
module life_like_automaton_step (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [lla_pkg::OP_W-1:0]        operation,
    input  logic [lla_pkg::COORD_W-1:0]     column,
    input  logic [lla_pkg::COORD_W-1:0]     row,
    input  logic                            alive_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            alive_out,
    output logic [lla_pkg::OP_W-1:0]        operation_done,
    input  logic                            cfg_wr_en,
    input  logic [lla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lla_pkg::MASK_W-1:0]      cfg_data
);
    import lla_pkg::*;

    lla_cmd_t    cmd;
    lla_status_t status;

    lla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .status    (status),
        .cmd       (cmd)
    );

    lla_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .operation      (operation),
        .column         (column),
        .row            (row),
        .alive_in       (alive_in),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .alive_out      (alive_out),
        .operation_done (operation_done)
    );

endmodule

// ===== bench/grid_checker.sv =====
`timescale 1ns / 1ps

module grid_checker
    import lla_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [OP_W-1:0]    operation,
    input  logic [COORD_W-1:0] column,
    input  logic [COORD_W-1:0] row,
    input  logic               alive_in,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               alive_out,
    input  logic [OP_W-1:0]    operation_done,
    input  logic               cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MASK_W-1:0]  cfg_data,
    output int                 mismatches,
    output int                 outstanding
);

    typedef struct packed {
        logic            alive;
        logic [OP_W-1:0] op;
    } cell_result_t;

    // two planes, front is the one reads and writes go to
    bit                cells [2][GRID_HEIGHT][GRID_WIDTH];
    bit                front;
    logic [MASK_W-1:0] birth_rule;
    logic [MASK_W-1:0] survive_rule;
    cell_result_t      result_q [$];
    cell_result_t      want;

    function automatic bit cell_alive(input bit pl, input int r, input int c);
        if (r < 0 || r >= GRID_HEIGHT || c < 0 || c >= GRID_WIDTH)
            return 1'b0;
        return cells[pl][r][c];
    endfunction

    function automatic int live_neighbours(input int r, input int c);
        int n;
        n = 0;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if (dr != 0 || dc != 0)
                    n += cell_alive(front, r + dr, c + dc);
        return n;
    endfunction

    task automatic next_generation();
        bit                back;
        logic [MASK_W-1:0] rule;
        back = ~front;
        for (int r = 0; r < GRID_HEIGHT; r++)
            for (int c = 0; c < GRID_WIDTH; c++)
            begin
                rule = cells[front][r][c] ? survive_rule : birth_rule;
                cells[back][r][c] = rule[live_neighbours(r, c)];
            end
        front = back;
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic predict_cell_op(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] c,
                                   input logic [COORD_W-1:0] r, input logic a);
        logic alive;
        bit   on_grid;
        alive   = 1'b0;
        on_grid = (c < GRID_WIDTH) && (r < GRID_HEIGHT);
        case (op)
            OP_WRITE:   if (on_grid) cells[front][r][c] = a;
            OP_ADVANCE: next_generation();
            OP_READ:    if (on_grid) alive = cells[front][r][c];
            default:    ;
        endcase
        result_q.push_back('{alive: alive, op: op});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (cells[p, r, c])
                cells[p][r][c] = 1'b0;
            front        = 1'b0;
            birth_rule   = BIRTH_RESET;
            survive_rule = SURVIVAL_RESET;
            result_q.delete();
            mismatches   = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en === 1'b1)
                case (cfg_index)
                    REG_BIRTH:    birth_rule   = cfg_data;
                    REG_SURVIVAL: survive_rule = cfg_data;
                    default:      ;
                endcase

            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                if (result_q.size() == 0)
                    report_mismatch($sformatf("result alive_out=%0b operation_done=%0d, none outstanding",
                                              alive_out, operation_done));
                else
                begin
                    want = result_q.pop_front();
                    if (alive_out !== want.alive)
                        report_mismatch($sformatf("alive_out %0b, expected %0b (op %0d)",
                                                  alive_out, want.alive, want.op));
                    if (operation_done !== want.op)
                        report_mismatch($sformatf("operation_done %0d, expected %0d",
                                                  operation_done, want.op));
                end
            end

            if (in_valid === 1'b1 && in_ready === 1'b1)
                predict_cell_op(operation, column, row, alive_in);

            outstanding <= result_q.size();
        end
    end

endmodule

// ===== bench/life_like_automaton_step_test.sv =====
`timescale 1ns / 1ps

module life_like_automaton_step_test;
    import lla_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int PHASES          = 8;
    localparam int WINDOW          = 8;
    localparam int CYCLE_LIMIT     = 1_000_000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [OP_W-1:0]      operation;
    logic [COORD_W-1:0]   column;
    logic [COORD_W-1:0]   row;
    logic                 alive_in;
    logic                 out_valid;
    logic                 out_ready;
    logic                 alive_out;
    logic [OP_W-1:0]      operation_done;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MASK_W-1:0]    cfg_data;

    int mismatches;
    int outstanding;
    int sent;
    int gap_pct;
    int stall_pct;
    int cycles = 0;

    life_like_automaton_step dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .column         (column),
        .row            (row),
        .alive_in       (alive_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .alive_out      (alive_out),
        .operation_done (operation_done),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    grid_checker grid_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .column         (column),
        .row            (row),
        .alive_in       (alive_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .alive_out      (alive_out),
        .operation_done (operation_done),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // called at a clock edge; returns at the edge where the transfer happens
    task automatic send_item(input logic [OP_W-1:0] op, input int c, input int r, input logic a);
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < gap_pct)
                @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        column    <= c[COORD_W-1:0];
        row       <= r[COORD_W-1:0];
        alive_in  <= a;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        sent++;
    endtask

    // drain all outstanding results, then wait so the block is idle
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [MASK_W-1:0] birth;
        logic [MASK_W-1:0] survive;
        int                x0;
        int                y0;

        in_valid  = 1'b0;
        operation = OP_WRITE;
        column    = '0;
        row       = '0;
        alive_in  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_BIRTH;
        cfg_data  = '0;
        out_ready = 1'b0;
        gap_pct   = 0;
        stall_pct = 0;
        sent      = 0;
        rst_n     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset rule B3/S23
        send_item(OP_READ, 0, 0, 1'b0);             // untouched cell reads dead
        send_item(OP_WRITE, 0, 0, 1'b1);
        send_item(OP_WRITE, 1, 0, 1'b1);
        send_item(OP_WRITE, 0, 1, 1'b1);
        send_item(OP_WRITE, 63, 63, 1'b1);
        send_item(OP_WRITE, 63, 0, 1'b1);
        send_item(OP_READ, 63, 63, 1'b0);
        send_item(OP_UNUSED, 63, 63, 1'b1);         // must change nothing
        send_item(OP_READ, 63, 63, 1'b0);
        send_item(OP_ADVANCE, 63, 63, 1'b1);        // fields ignored
        send_item(OP_READ, 1, 1, 1'b0);             // birth in corner
        send_item(OP_READ, 0, 0, 1'b0);
        send_item(OP_READ, 63, 63, 1'b0);           // no wrap: lone corners die
        send_item(OP_READ, 63, 0, 1'b0);
        send_item(OP_WRITE, 10, 63, 1'b1);          // blinker on the bottom edge
        send_item(OP_WRITE, 11, 63, 1'b1);
        send_item(OP_WRITE, 12, 63, 1'b1);
        send_item(OP_ADVANCE, 0, 0, 1'b0);
        send_item(OP_READ, 11, 62, 1'b0);
        send_item(OP_READ, 10, 63, 1'b0);
        send_item(OP_READ, 11, 63, 1'b0);
        send_item(OP_WRITE, 0, 0, 1'b0);
        send_item(OP_READ, 0, 0, 1'b1);
        send_item(OP_UNUSED, 0, 0, 1'b0);
        settle();

        sent = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin birth = BIRTH_RESET; survive = SURVIVAL_RESET; end
                1:       begin birth = '0;          survive = '0;             end
                2:       begin birth = '1;          survive = '1;             end
                3:       begin birth = '1;          survive = '0;             end
                4:       begin birth = '0;          survive = '1;             end
                5:       begin birth = 9'h048;      survive = SURVIVAL_RESET; end
                default:
                begin
                    birth   = MASK_W'($urandom_range(511));
                    survive = MASK_W'($urandom_range(511));
                end
            endcase
            case (p % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 56; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 56; end
                default: begin gap_pct = 11; stall_pct = 11; end
            endcase

            cfg_wr_en <= 1'b1;
            cfg_index <= REG_BIRTH;
            cfg_data  <= birth;
            @(posedge clk);
            cfg_index <= REG_SURVIVAL;
            cfg_data  <= survive;
            @(posedge clk);
            cfg_wr_en <= 1'b0;

            while (sent < (p + 1) * ITEMS_PER_PHASE)
            begin
                if ($urandom_range(9) < 7)
                begin
                    // seed a small window, evolve it, then probe around it
                    case ($urandom_range(3))
                        0:       x0 = 0;
                        1:       x0 = GRID_WIDTH - WINDOW;
                        default: x0 = $urandom_range(GRID_WIDTH - WINDOW);
                    endcase
                    case ($urandom_range(3))
                        0:       y0 = 0;
                        1:       y0 = GRID_HEIGHT - WINDOW;
                        default: y0 = $urandom_range(GRID_HEIGHT - WINDOW);
                    endcase
                    repeat ($urandom_range(10, 30))
                        send_item(OP_WRITE, x0 + $urandom_range(WINDOW - 1),
                                  y0 + $urandom_range(WINDOW - 1), $urandom_range(9) < 6);
                    repeat ($urandom_range(1, 3))
                        send_item(OP_ADVANCE, $urandom_range(63), $urandom_range(63),
                                  1'($urandom_range(1)));
                    // one cell past the window edge; -1 lands on the far side
                    repeat ($urandom_range(5, 12))
                        send_item(OP_READ, x0 - 1 + $urandom_range(WINDOW + 1),
                                  y0 - 1 + $urandom_range(WINDOW + 1), 1'($urandom_range(1)));
                end
                else
                begin
                    repeat ($urandom_range(1, 6))
                        send_item(OP_W'($urandom_range(3)), $urandom_range(63),
                                  $urandom_range(63), 1'($urandom_range(1)));
                end
            end
            settle();
        end

        repeat (GRID_HEIGHT + 8) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
